/* sv/bfdh_pkg.sv */
// shared constants, types and state encoding for the bloom filter block
package bfdh_pkg;

   localparam int MAX_BYTES  = 4096;
   localparam int MAX_HASHES = 16;

   localparam int ADDR_W  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int MAX_LOG = $clog2(MAX_BYTES + 1) - 1;
   localparam int K_W     = $clog2(MAX_HASHES + 1);
   localparam int CNT_W   = 32;
   localparam int PROD_W  = CNT_W + K_W;

   localparam int FP_W    = 64;
   localparam int HASH_W  = 32;
   localparam int HC_W    = 5;
   localparam int LOG_W   = 4;
   localparam int CSR_W   = 5;
   localparam int IDX_W   = 1;

   localparam logic [IDX_W-1:0] REG_HASH_COUNT = 1'd0;
   localparam logic [IDX_W-1:0] REG_LOG_SIZE   = 1'd1;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   localparam logic [HC_W-1:0]  HASH_COUNT_RESET = 5'd4;
   localparam logic [LOG_W-1:0] LOG_SIZE_RESET   = 4'd12;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_MODIFY,
      ST_DONE
   } state_type;

endpackage

/* sv/bfdh_req_if.sv */
// request channel: operation and fingerprint
interface bfdh_req_if;
   import bfdh_pkg::*;

   logic            valid;
   logic            ready;
   logic            func;
   logic [FP_W-1:0] fingerprint;

   modport source (output valid, output func, output fingerprint, input ready);
   modport sink   (input valid, input func, input fingerprint, output ready);
endinterface

/* sv/bfdh_rsp_if.sv */
// response channel: membership and capacity flags
interface bfdh_rsp_if;
   import bfdh_pkg::*;

   logic valid;
   logic ready;
   logic present;
   logic valid_res;

   modport source (output valid, output present, output valid_res, input ready);
   modport sink   (input valid, input present, input valid_res, output ready);
endinterface

/* sv/bloom_filter_double_hash.sv */
// bloom filter with double hashing over a single byte-wide bitmap memory
//
//   channel    dir  handshake        payload
//   req_chan   in   valid / ready    func, fingerprint
//   rsp_chan   out  valid / ready    present, valid_res
//   csr_*      in   csr_wr_en only   csr_index, csr_wdata
//
// each active probe of an item is a memory read state (ST_READ) and a
// modify/write-back state (ST_MODIFY) on the bitmap ram.
// after reset a clearing pass zeroes all MAX_BYTES bytes of the bitmap, one
// byte a cycle; no transaction is accepted then, csr writes are.
// a finished result sits in the output register; the next request is
// accepted meanwhile and its result waits only if the register is still full.
module bloom_filter_double_hash (
   input  logic                     clock,
   input  logic                     reset,
   bfdh_req_if.sink                 req_chan,
   bfdh_rsp_if.source               rsp_chan,
   input  logic                     csr_wr_en,
   input  logic [bfdh_pkg::IDX_W-1:0] csr_index,
   input  logic [bfdh_pkg::CSR_W-1:0] csr_wdata
);
   import bfdh_pkg::*;

   state_type state_ff, state_in;

   logic [HC_W-1:0]   hash_count_ff;
   logic [LOG_W-1:0]  log_size_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [K_W-1:0]    probe_ff, probe_in;
   logic [HASH_W-1:0] pos_ff, pos_in;
   logic [HASH_W-1:0] step_ff, step_in;
   logic              func_ff, func_in;
   logic              all_set_ff, all_set_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [7:0]        bit_ff, bit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              present_ff, present_in;
   logic              valid_res_ff, valid_res_in;

   logic [7:0]        mem [MAX_BYTES];
   logic [7:0]        mem_rdata_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;

   logic [LOG_W-1:0]  active_lg;
   logic [ADDR_W-1:0] addr_mask;
   logic [K_W-1:0]    active_k;
   logic [31:0]       hc_ext;
   logic [PROD_W-1:0] product;
   logic [PROD_W-1:0] bound;
   logic              req_take;
   logic              rsp_free;
   logic              probes_done;

   // active configuration
   always_comb begin
      active_lg = (32'(log_size_ff) > 32'(MAX_LOG)) ? LOG_W'(MAX_LOG) : log_size_ff;
      addr_mask = ~({ADDR_W{1'b1}} << active_lg);
      hc_ext    = 32'(hash_count_ff);
      active_k  = (hc_ext > 32'(MAX_HASHES)) ? K_W'(MAX_HASHES) : K_W'(hc_ext);
      product   = PROD_W'(count_ff) * PROD_W'(active_k);
      bound     = PROD_W'(8) << active_lg;
   end

   assign req_take    = req_chan.valid && req_chan.ready;
   assign rsp_free    = !rsp_valid_ff || rsp_chan.ready;
   assign probes_done = (probe_ff == active_k);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_ff == ADDR_W'(MAX_BYTES - 1)) state_in = ST_IDLE;
         ST_IDLE:   if (req_chan.valid) state_in = ST_READ;
         ST_READ:   state_in = probes_done ? ST_DONE : ST_MODIFY;
         ST_MODIFY: state_in = ST_READ;
         ST_DONE:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      mem_we         = 1'b0;
      mem_waddr      = addr_ff;
      mem_wdata      = mem_rdata_ff | bit_ff;
      mem_raddr      = pos_ff[3 +: ADDR_W] & addr_mask;
      clr_in         = clr_ff;
      count_in       = count_ff;
      probe_in       = probe_ff;
      pos_in         = pos_ff;
      step_in        = step_ff;
      func_in        = func_ff;
      all_set_in     = all_set_ff;
      addr_in        = addr_ff;
      bit_in         = bit_ff;
      present_in     = present_ff;
      valid_res_in   = valid_res_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = 8'd0;
            clr_in    = clr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (req_take) begin
               func_in    = req_chan.func;
               pos_in     = req_chan.fingerprint[FP_W-1 -: HASH_W];
               step_in    = req_chan.fingerprint[HASH_W-1:0];
               probe_in   = '0;
               all_set_in = 1'b1;
            end
         end
         ST_READ: begin
            addr_in = pos_ff[3 +: ADDR_W] & addr_mask;
            bit_in  = 8'(1) << pos_ff[2:0];
            if (probes_done && func_ff == FUNC_INSERT && count_ff != '1) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         ST_MODIFY: begin
            if (func_ff == FUNC_INSERT) begin
               mem_we = 1'b1;
            end else if ((mem_rdata_ff & bit_ff) == 8'd0) begin
               all_set_in = 1'b0;
            end
            pos_in   = pos_ff + step_ff;
            probe_in = probe_ff + K_W'(1);
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               present_in   = (func_ff == FUNC_QUERY) && all_set_ff;
               valid_res_in = (product <= bound);
            end
         end
         default: ;
      endcase
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.present   = present_ff;
   assign rsp_chan.valid_res = valid_res_ff;

   // bitmap ram, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         hash_count_ff <= HASH_COUNT_RESET;
         log_size_ff   <= LOG_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_HASH_COUNT: hash_count_ff <= csr_wdata[HC_W-1:0];
               REG_LOG_SIZE:   log_size_ff   <= csr_wdata[LOG_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      probe_ff     <= probe_in;
      pos_ff       <= pos_in;
      step_ff      <= step_in;
      func_ff      <= func_in;
      all_set_ff   <= all_set_in;
      addr_ff      <= addr_in;
      bit_ff       <= bit_in;
      present_ff   <= present_in;
      valid_res_ff <= valid_res_in;
   end

endmodule
